// ----- rtl/core/bmst_pkg.sv -----
// Package for the bounded multiset table.
// Holds the request codes, controller states and cell control type.
// No dependencies.
package bmst_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int KEY_W        = 32;
    localparam int COUNT_OUT_W  = 8;
    localparam int REQ_W        = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_LOOKUP = 2'd2
    } req_type_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_UPDATE = 1'b1
    } state_t;

    typedef struct packed {
        logic write_en;
        logic shift_en;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/bmst_cell.sv -----
// One storage cell of the bounded multiset table chain.
// Holds one entry, compares it with the request key and takes its upper neighbour's entry on a shift.
// Depends on bmst_pkg.
module bmst_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 8
) (
    input  logic                            clk,
    input  logic [CNT_W-1:0]                count,
    input  logic [bmst_pkg::KEY_W-1:0]      cmp_key,
    input  logic [bmst_pkg::KEY_W-1:0]      wr_key,
    input  logic [bmst_pkg::KEY_W-1:0]      nbr_entry,
    input  bmst_pkg::cell_ctrl_t            ctrl,
    output logic [bmst_pkg::KEY_W-1:0]      entry,
    output logic                            match
);

    logic [bmst_pkg::KEY_W-1:0] entry_reg;
    logic [bmst_pkg::KEY_W-1:0] entry_next;
    logic                       active;

    assign active = CNT_W'(IDX) < count;
    assign match  = active && (entry_reg == cmp_key);
    assign entry  = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.write_en)
        begin
            entry_next = wr_key;
        end
        else if (ctrl.shift_en)
        begin
            entry_next = nbr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- rtl/core/bounded_multiset_table.sv -----
// One item is worked on at a time: on accept, the key is compared across the cell chain and the
// matches are registered; the insert or close-up shift of the chain follows in the update state,
// which waits while a finished result is still held unread in the output register.
// A finished result waits in the output register while the next item is accepted.
// Reset (rst_n, asynchronous, active low) empties the table; entries themselves are not cleared.
// Depends on bmst_pkg and bmst_cell.
module bounded_multiset_table #(
    parameter int CAPACITY = bmst_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key_value
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] success, [8:1] entry_count, [15:9] zero
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (CNT_W > bmst_pkg::COUNT_OUT_W) ? CNT_W : bmst_pkg::COUNT_OUT_W;

    bmst_pkg::state_t    state_reg;
    bmst_pkg::state_t    state_next;
    bmst_pkg::req_type_t req_reg;
    logic [bmst_pkg::KEY_W-1:0] key_reg;
    logic [CAPACITY-1:0] match_reg;
    logic [CAPACITY-1:0] match_now;
    logic [CAPACITY-1:0] below_first;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                success_reg;
    logic                success_next;
    logic [bmst_pkg::COUNT_OUT_W-1:0] out_count_reg;
    logic [EXT_W-1:0]    count_ext;
    logic                accept;
    logic                update_fire;
    logic                full;
    logic                hit;
    logic                do_insert;
    logic                do_delete;

    bmst_pkg::cell_ctrl_t       ctrl [CAPACITY];
    logic [bmst_pkg::KEY_W-1:0] entry [CAPACITY];

    assign accept      = s_tvalid && s_tready;
    assign update_fire = (state_reg == bmst_pkg::ST_UPDATE) && (!out_valid_reg || m_tready);
    assign full        = (count_reg == CNT_W'(CAPACITY));
    assign hit         = |match_reg;
    assign do_insert   = update_fire && (req_reg == bmst_pkg::REQ_INSERT) && !full;
    assign do_delete   = update_fire && (req_reg == bmst_pkg::REQ_DELETE) && hit;
    assign below_first = (match_reg - CAPACITY'(1)) & ~match_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [bmst_pkg::KEY_W-1:0] nbr;

            if (gi == CAPACITY - 1)
            begin : g_top
                assign nbr = entry[gi];
            end
            else
            begin : g_mid
                assign nbr = entry[gi+1];
            end

            assign ctrl[gi].write_en = do_insert && (count_reg == CNT_W'(gi));
            assign ctrl[gi].shift_en = do_delete && !below_first[gi];

            bmst_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk       (clk),
                .count     (count_reg),
                .cmp_key   (s_tdata),
                .wr_key    (key_reg),
                .nbr_entry (nbr),
                .ctrl      (ctrl[gi]),
                .entry     (entry[gi]),
                .match     (match_now[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bmst_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = bmst_pkg::ST_UPDATE;
                end
            end
            bmst_pkg::ST_UPDATE:
            begin
                if (update_fire)
                begin
                    state_next = bmst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bmst_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == bmst_pkg::ST_IDLE);
    end

    always_comb
    begin
        count_next   = count_reg;
        success_next = 1'b0;
        case (req_reg)
            bmst_pkg::REQ_INSERT:
            begin
                success_next = !full;
                if (!full)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            bmst_pkg::REQ_DELETE:
            begin
                success_next = hit;
                if (hit)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            bmst_pkg::REQ_LOOKUP:
            begin
                success_next = hit;
            end
            default:
            begin
                success_next = 1'b0;
            end
        endcase
    end

    assign count_ext = EXT_W'(count_next);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (update_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bmst_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (update_fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= bmst_pkg::req_type_t'(s_tuser);
            key_reg   <= s_tdata;
            match_reg <= match_now;
        end
        if (update_fire)
        begin
            success_reg   <= success_next;
            out_count_reg <= count_ext[bmst_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_count_reg, success_reg};

endmodule

// ----- rtl/core/bmst_checker.sv -----
// Port-level checker for the bounded multiset table, bound to the top level.
// Depends on bounded_multiset_table and bmst_pkg.
module bmst_checker #(
    parameter int CAPACITY = bmst_pkg::CAPACITY_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // One item is worked on at a time, so the input side closes after an accept.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is still in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

    // When the capacity is below 256, the reported entry count never exceeds it.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (CAPACITY < 256)) |-> (int'(m_tdata[8:1]) <= CAPACITY))
        else $error("entry count above capacity");

    // Padding bits of a result stay zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:9] == 7'd0))
        else $error("result padding not zero");

endmodule

bind bounded_multiset_table bmst_checker #(
    .CAPACITY (CAPACITY)
) u_bmst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/tb.sv -----
// Self-checking testbench for bounded_multiset_table: inserts, deletes, lookups and
// unused request codes are streamed in, and every result is compared with a multiset
// predictor kept in the bench. Depends on bmst_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;

    localparam int CAPACITY = bmst_pkg::CAPACITY_DEF;
    localparam logic [bmst_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 880;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                             success;
        logic [bmst_pkg::COUNT_OUT_W-1:0] entry_count;
    } table_reply_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [bmst_pkg::KEY_W-1:0] s_tdata = '0;   // [31:0] key_value
    logic [bmst_pkg::REQ_W-1:0] s_tuser = '0;   // [1:0] req_type
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [15:0]                m_tdata;        // [0] success, [8:1] entry_count, [15:9] zero

    logic [bmst_pkg::KEY_W-1:0] table_keys [CAPACITY];
    int                         table_fill = 0;
    logic [bmst_pkg::KEY_W-1:0] key_pool [16];
    table_reply_t               awaited_replies [$];
    int                         error_count = 0;
    int                         cycle_count = 0;
    int                         burst_left = 0;
    int                         hold_ticket = 0;

    bounded_multiset_table #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb failed");
        $finish;
    end

    function automatic table_reply_t predict_reply(input logic [bmst_pkg::REQ_W-1:0] kind,
                                                   input logic [bmst_pkg::KEY_W-1:0] key);
        table_reply_t reply;
        int           pos;
        int           i;
        reply.success = 1'b0;
        pos = -1;
        for (i = 0; i < table_fill; i++)
        begin
            if (pos < 0 && table_keys[i] == key)
            begin
                pos = i;
            end
        end
        if (kind == bmst_pkg::REQ_INSERT)
        begin
            if (table_fill < CAPACITY)
            begin
                table_keys[table_fill] = key;
                table_fill++;
                reply.success = 1'b1;
            end
        end
        else if (kind == bmst_pkg::REQ_DELETE)
        begin
            if (pos >= 0)
            begin
                table_fill--;
                table_keys[pos] = table_keys[table_fill];
                reply.success = 1'b1;
            end
        end
        else if (kind == bmst_pkg::REQ_LOOKUP)
        begin
            reply.success = (pos >= 0);
        end
        reply.entry_count = table_fill[bmst_pkg::COUNT_OUT_W-1:0];
        return reply;
    endfunction

    // The sender offers items in bursts of random length, with random gaps between bursts.
    task automatic issue_request(input logic [bmst_pkg::REQ_W-1:0] kind,
                                 input logic [bmst_pkg::KEY_W-1:0] key);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        awaited_replies.push_back(predict_reply(kind, key));
    endtask

    function automatic logic [bmst_pkg::KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) < 6)
        begin
            return key_pool[$urandom_range(0, 15)];
        end
        return $urandom();
    endfunction

    function automatic logic [bmst_pkg::REQ_W-1:0] pick_kind(input bit filling);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < (filling ? 55 : 20))
        begin
            return bmst_pkg::REQ_INSERT;
        end
        if (roll < (filling ? 75 : 65))
        begin
            return bmst_pkg::REQ_DELETE;
        end
        if (roll < 95)
        begin
            return bmst_pkg::REQ_LOOKUP;
        end
        return REQ_UNUSED;
    endfunction

    // A delete names a stored value half the time, so the close-up path is exercised.
    function automatic logic [bmst_pkg::KEY_W-1:0] pick_key_for(
        input logic [bmst_pkg::REQ_W-1:0] kind);
        if (kind != bmst_pkg::REQ_INSERT && table_fill > 0 && $urandom_range(0, 1) == 1)
        begin
            return table_keys[$urandom_range(0, table_fill - 1)];
        end
        return pick_key();
    endfunction

    task automatic test_directed_cases();
        issue_request(bmst_pkg::REQ_LOOKUP, 32'h0000_0000);
        issue_request(bmst_pkg::REQ_DELETE, 32'h8000_0000);
        issue_request(bmst_pkg::REQ_INSERT, 32'h8000_0000);
        issue_request(bmst_pkg::REQ_INSERT, 32'h7FFF_FFFF);
        issue_request(bmst_pkg::REQ_INSERT, 32'h0000_0000);
        issue_request(bmst_pkg::REQ_INSERT, 32'hFFFF_FFFF);
        issue_request(bmst_pkg::REQ_INSERT, 32'h7FFF_FFFF);
        issue_request(bmst_pkg::REQ_LOOKUP, 32'h8000_0000);
        issue_request(bmst_pkg::REQ_LOOKUP, 32'h8000_0001);
        issue_request(bmst_pkg::REQ_LOOKUP, 32'hFFFF_FFFE);
        issue_request(REQ_UNUSED, 32'hFFFF_FFFF);
        issue_request(REQ_UNUSED, 32'h0000_0000);
        issue_request(bmst_pkg::REQ_DELETE, 32'h7FFF_FFFF);
        issue_request(bmst_pkg::REQ_LOOKUP, 32'h7FFF_FFFF);
        issue_request(bmst_pkg::REQ_DELETE, 32'h7FFF_FFFF);
        issue_request(bmst_pkg::REQ_LOOKUP, 32'h7FFF_FFFF);
        issue_request(bmst_pkg::REQ_INSERT, 32'h1234_5678);
        issue_request(bmst_pkg::REQ_DELETE, 32'h1234_5678);
        issue_request(bmst_pkg::REQ_DELETE, 32'h0000_0000);
        issue_request(bmst_pkg::REQ_DELETE, 32'h8000_0000);
        issue_request(bmst_pkg::REQ_DELETE, 32'hFFFF_FFFF);
        issue_request(bmst_pkg::REQ_DELETE, 32'hFFFF_FFFF);
        issue_request(bmst_pkg::REQ_LOOKUP, 32'hFFFF_FFFF);
    endtask

    task automatic test_fill_and_drain();
        while (table_fill < CAPACITY)
        begin
            issue_request(bmst_pkg::REQ_INSERT, pick_key());
        end
        issue_request(bmst_pkg::REQ_INSERT, 32'h5A5A_A5A5);
        issue_request(bmst_pkg::REQ_LOOKUP, table_keys[CAPACITY - 1]);
        issue_request(REQ_UNUSED, table_keys[0]);
        while (table_fill > 0)
        begin
            issue_request(bmst_pkg::REQ_DELETE, table_keys[$urandom_range(0, table_fill - 1)]);
        end
        issue_request(bmst_pkg::REQ_DELETE, table_keys[0]);
    endtask

    task automatic test_random_traffic(input int n_items);
        int                         i;
        bit                         filling;
        logic [bmst_pkg::REQ_W-1:0] kind;
        filling = 1'b1;
        for (i = 0; i < n_items; i++)
        begin
            if (table_fill == CAPACITY && $urandom_range(0, 7) == 0)
            begin
                filling = 1'b0;
            end
            else if (table_fill == 0 || $urandom_range(0, 199) == 0)
            begin
                filling = (table_fill == 0) ? 1'b1 : !filling;
            end
            kind = pick_kind(filling);
            issue_request(kind, pick_key_for(kind));
        end
    endtask

    task automatic test_output_hold_off();
        int                         i;
        logic [bmst_pkg::REQ_W-1:0] kind;
        hold_ticket++;
        for (i = 0; i < 40; i++)
        begin
            kind = pick_kind(1'b1);
            issue_request(kind, pick_key_for(kind));
        end
    endtask

    // The receiver switches between random stall patterns and can be told to hold off.
    initial
    begin : receiver
        int mode;
        int tick;
        int hold_left;
        int hold_seen;
        mode = 0;
        tick = 0;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_ticket != hold_seen)
            begin
                hold_seen = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (tick % 64 == 0)
            begin
                mode = $urandom_range(0, 3);
            end
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 2) != 0);
                    2: m_tready <= (tick % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 1) == 1);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_checker
        table_reply_t wanted;
        if (rst_n && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (awaited_replies.size() == 0)
            begin
                if (error_count < REPORT_LIMIT)
                begin
                    $display("unexpected result: success %b entry_count %0d",
                             m_tdata[0], m_tdata[8:1]);
                end
                error_count++;
            end
            else
            begin
                wanted = awaited_replies.pop_front();
                if (m_tdata[0] !== wanted.success || m_tdata[8:1] !== wanted.entry_count)
                begin
                    if (error_count < REPORT_LIMIT)
                    begin
                        $display("mismatch: expected success %b entry_count %0d, got %b %0d",
                                 wanted.success, wanted.entry_count,
                                 m_tdata[0], m_tdata[8:1]);
                    end
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int k = 4; k < 16; k++)
        begin
            key_pool[k] = $urandom();
        end
        test_directed_cases();
        test_fill_and_drain();
        test_output_hold_off();
        test_random_traffic(RANDOM_ITEMS);
        s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
